// ===== design/timed_frame_window_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// timed frame window buffer assertion macros
// immediate-style wrappers around concurrent properties used by the checker
// ----------------------------------------------------------------------------
`ifndef TIMED_FRAME_WINDOW_BUFFER_ASSERT_SVH
`define TIMED_FRAME_WINDOW_BUFFER_ASSERT_SVH

// same-cycle implication
`define TFWB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFWB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tfwb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfwb_pkg
// shared types and constants of the timed frame window buffer
// ----------------------------------------------------------------------------
package tfwb_pkg;

   localparam int STAMP_W  = 32;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 3;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NEWEST  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_OLD = 3'd5;

   localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd10000;

   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

   typedef struct packed {
      logic                cmd;
      logic [STAMP_W-1:0]  now_time;
      logic [STAMP_W-1:0]  stamp;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
   } rsp_type;

   typedef enum logic {
      OP_ADD,
      OP_LOOKUP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STAMP_W-1:0]  now_time;
      logic [STAMP_W-1:0]  stamp;
      logic [HANDLE_W-1:0] handle;
   } job_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/tfwb_ram.sv =====
// ----------------------------------------------------------------------------
// tfwb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tfwb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tfwb_div.sv =====
// ----------------------------------------------------------------------------
// tfwb_div
// bit-serial restoring divider, one quotient bit per cycle, quotient < 2**Q
// ----------------------------------------------------------------------------
module tfwb_div
   import tfwb_pkg::*;
#(
   parameter int Q = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [STAMP_W+Q-1:0] num,
   input  logic [STAMP_W-1:0]   den,
   output logic                 done,
   output logic [Q-1:0]         quot
);

   localparam int CNT_W = $clog2(Q + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [STAMP_W-1:0] rem_ff;
   logic [Q-1:0]       sq_ff;
   logic [STAMP_W-1:0] den_ff;

   logic [STAMP_W:0]   trial;
   logic [STAMP_W:0]   diff;
   logic               qbit;
   logic [STAMP_W-1:0] rem_in;
   logic [Q:0]         sq_ext;
   logic [Q-1:0]       sq_in;

   assign trial  = {rem_ff, sq_ff[Q-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign qbit   = (trial >= {1'b0, den_ff});
   assign rem_in = qbit ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
   assign sq_ext = {sq_ff, qbit};
   assign sq_in  = sq_ext[Q-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(Q);
            rem_ff  <= num[STAMP_W+Q-1:Q];
            sq_ff   <= num[Q-1:0];
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sq_ff  <= sq_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = sq_ff;

endmodule

// ===== design/tfwb_front.sv =====
// ----------------------------------------------------------------------------
// tfwb_front
// request intake: classifies each beat and queues it for the back end
// ----------------------------------------------------------------------------
module tfwb_front
   import tfwb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job_data,
   input  logic    job_pop
);

   localparam int FILL_W = JOBQ_AW + 1;

   job_type              q_ff [JOBQ_DEPTH];
   logic [JOBQ_AW-1:0]   wr_ptr_ff;
   logic [JOBQ_AW-1:0]   rd_ptr_ff;
   logic [FILL_W-1:0]    fill_ff;

   logic    push;
   logic    pop;
   job_type job_in;

   assign req_stall = (fill_ff == FILL_W'(JOBQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = job_pop && job_valid;

   always_comb begin
      job_in.op       = (req_data.cmd == CMD_LOOKUP) ? OP_LOOKUP : OP_ADD;
      job_in.now_time = req_data.now_time;
      job_in.stamp    = req_data.stamp;
      job_in.handle   = req_data.handle_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + JOBQ_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + JOBQ_AW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

   assign job_valid = (fill_ff != '0);
   assign job_data  = q_ff[rd_ptr_ff];

endmodule

// ===== design/tfwb_back.sv =====
// ----------------------------------------------------------------------------
// tfwb_back
// frame ring execution: eviction walk, append, lookup with interpolation
// ----------------------------------------------------------------------------
module tfwb_back
   import tfwb_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job_data,
   output logic               job_pop,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STAMP_W-1:0] csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int NW = STAMP_W + IW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EV_RD,
      S_EV_CHK,
      S_EV_APPLY,
      S_ADD_WR,
      S_LK_OLD,
      S_LK_NEW,
      S_LK_CMP,
      S_LK_MUL,
      S_LK_START,
      S_LK_DIV,
      S_LK_RD,
      S_LK_HIT,
      S_PUT
   } state_type;

   state_type          state_ff;
   logic [STAMP_W-1:0] window_ff;
   logic [IW-1:0]      head_ff;
   logic [CW-1:0]      count_ff;
   job_type            job_ff;
   logic [CW-1:0]      old_ff;
   logic [STAMP_W-1:0] oldest_ff;
   logic [STAMP_W-1:0] diff_ff;
   logic [STAMP_W-1:0] den_ff;
   logic [NW-1:0]      num_ff;
   logic [IW-1:0]      pos_ff;
   rsp_type            res_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;
   entry_type          wr_entry;
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [IW-1:0]      ram_rd_addr;

   logic [STAMP_W-1:0] ev_age;
   logic               ev_is_old;
   logic [CW-1:0]      old_next;
   logic [CW-1:0]      count_m1;
   logic               out_free;
   logic               div_start;
   logic               div_done;
   logic [IW-1:0]      div_quot;

   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign rd_entry  = entry_type'(ram_rd_data);
   assign ev_age    = job_ff.now_time - rd_entry.stamp;
   assign ev_is_old = (job_ff.now_time > rd_entry.stamp) && (ev_age > window_ff);
   assign old_next  = old_ff + CW'(1);
   assign count_m1  = count_ff - CW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign job_pop   = (state_ff == S_IDLE) && job_valid;
   assign div_start = (state_ff == S_LK_START);
   assign csr_ready = 1'b1;

   assign ram_wr_en       = (state_ff == S_ADD_WR) && (count_ff < CW'(DEPTH));
   assign ram_wr_addr     = slot_of(head_ff, count_ff);
   assign wr_entry.stamp  = job_ff.stamp;
   assign wr_entry.handle = job_ff.handle;

   always_comb begin
      unique case (state_ff)
         S_EV_RD:  ram_rd_addr = slot_of(head_ff, old_ff);
         S_LK_NEW: ram_rd_addr = slot_of(head_ff, count_m1);
         S_LK_RD:  ram_rd_addr = slot_of(head_ff, CW'(pos_ff));
         default:  ram_rd_addr = head_ff;
      endcase
   end

   tfwb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tfwb_div #(
      .Q (IW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_data;
         end
         if ((state_ff == S_PUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  old_ff <= '0;
                  if (job_data.op == OP_ADD) begin
                     state_ff <= (count_ff != '0) ? S_EV_RD : S_EV_APPLY;
                  end else if (count_ff == '0) begin
                     res_ff.status     <= ST_EMPTY;
                     res_ff.handle_out <= '0;
                     state_ff          <= S_PUT;
                  end else begin
                     state_ff <= S_LK_OLD;
                  end
               end
            end
            S_EV_RD: begin
               state_ff <= S_EV_CHK;
            end
            S_EV_CHK: begin
               if (ev_is_old) begin
                  old_ff   <= old_next;
                  state_ff <= (old_next < count_ff) ? S_EV_RD : S_EV_APPLY;
               end else begin
                  state_ff <= S_EV_APPLY;
               end
            end
            S_EV_APPLY: begin
               if (old_ff > CW'(1)) begin
                  head_ff  <= slot_of(head_ff, old_ff - CW'(1));
                  count_ff <= count_ff - (old_ff - CW'(1));
               end
               state_ff <= S_ADD_WR;
            end
            S_ADD_WR: begin
               res_ff.handle_out <= '0;
               if (count_ff < CW'(DEPTH)) begin
                  count_ff      <= count_ff + CW'(1);
                  res_ff.status <= ST_ADDED;
               end else begin
                  res_ff.status <= ST_FULL;
               end
               state_ff <= S_PUT;
            end
            S_LK_OLD: begin
               state_ff <= S_LK_NEW;
            end
            S_LK_NEW: begin
               oldest_ff <= rd_entry.stamp;
               state_ff  <= S_LK_CMP;
            end
            S_LK_CMP: begin
               if (job_ff.stamp < oldest_ff) begin
                  res_ff.status     <= ST_TOO_OLD;
                  res_ff.handle_out <= '0;
                  state_ff          <= S_PUT;
               end else if (job_ff.stamp >= rd_entry.stamp) begin
                  res_ff.status     <= ST_NEWEST;
                  res_ff.handle_out <= rd_entry.handle;
                  state_ff          <= S_PUT;
               end else begin
                  diff_ff  <= job_ff.stamp - oldest_ff;
                  den_ff   <= rd_entry.stamp - oldest_ff;
                  state_ff <= S_LK_MUL;
               end
            end
            S_LK_MUL: begin
               num_ff   <= NW'(diff_ff) * NW'(count_m1[IW-1:0]);
               state_ff <= S_LK_START;
            end
            S_LK_START: begin
               state_ff <= S_LK_DIV;
            end
            S_LK_DIV: begin
               if (div_done) begin
                  pos_ff   <= div_quot;
                  state_ff <= S_LK_RD;
               end
            end
            S_LK_RD: begin
               state_ff <= S_LK_HIT;
            end
            S_LK_HIT: begin
               res_ff.status     <= ST_INTERP;
               res_ff.handle_out <= rd_entry.handle;
               state_ff          <= S_PUT;
            end
            S_PUT: begin
               if (out_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/timed_frame_window_buffer.sv =====
// ----------------------------------------------------------------------------
// timed_frame_window_buffer
// ring store of timestamped frame handles with age eviction and time lookup
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | beat
//  req_    | in  | req_valid/req_stall | req_type: cmd, now_time, stamp, handle_in
//  rsp_    | out | rsp_valid/rsp_stall | rsp_type: status, handle_out
//  csr_    | in  | csr_valid/csr_ready | window_length, 32 bits
//
//  add: the eviction walk reads and checks k frames (k <= frame count), then writes
//  lookup: empty answers at once; too old or newest after reading the oldest and
//  newest stamps; interpolated then multiplies, divides bit-serially, reads again
//  reset: synchronous; frame store contents are not cleared
//  a two-beat request queue and an output register keep each side stalling alone
// ----------------------------------------------------------------------------
module timed_frame_window_buffer
   import tfwb_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STAMP_W-1:0] csr_data
);

   logic    job_valid;
   job_type job_data;
   logic    job_pop;

   tfwb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   tfwb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/tfwb_checker.sv =====
// ----------------------------------------------------------------------------
// tfwb_checker
// port-level checks on the timed frame window buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_frame_window_buffer_assert.svh"

module tfwb_checker
   import tfwb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input req_type            req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rsp_type            rsp_data,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [STAMP_W-1:0] csr_data
);

   logic [2:0] pending_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // beats taken in but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_beat && !rsp_beat) begin
         pending_ff <= pending_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_ff <= pending_ff - 3'd1;
      end
   end

   `TFWB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response beat changed or vanished")
   `TFWB_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "response valid straight out of reset")
   `TFWB_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, pending_ff != 3'd0, "response with no request outstanding")
   `TFWB_ASSERT_NOW(a_idle_accepts, clock, reset, pending_ff == 3'd0, !req_stall && csr_ready, "idle block refuses a beat")

endmodule

bind timed_frame_window_buffer tfwb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
